[src/pwl_pkg.sv]
// shared types, constants and codes for the pi pwm loop with square reference
// no dependencies; every other file refers to this package by scoped names
package pwl_pkg;

  // waveform and capture geometry
  localparam int WAVE_PERIOD    = 1000;
  localparam int WAVE_W         = $clog2(WAVE_PERIOD);
  localparam int DECIMATE_BY    = 10;
  localparam int DEC_W          = 4;
  localparam int CAPTURE_POINTS = 200;
  localparam int SLOT_W         = 8;

  // field widths
  localparam int ADC_W   = 10;
  localparam int ERR_W   = ADC_W + 1;
  localparam int GAIN_W  = 16;
  localparam int INTEG_W = 16;
  localparam int LIM_W   = 15;
  localparam int PER_W   = 16;
  localparam int DUTY_W  = 16;

  // q8.8 drive scaling
  localparam int FULL_SCALE_Q8 = 100 * 256;
  localparam int OFFSET_Q8     = 50 * 256;
  localparam int U_W           = 15;

  // shared multiplier and accumulator
  localparam int OPND_W = 23;
  localparam int ACC_W  = 2 * OPND_W;

  // divide by full scale (1024 * 25): drop 10 low bits, then multiply by
  // ceil(2^26 / 25) and keep the bits above 26; exact for the 21-bit input
  localparam int RECIP_PRE   = 10;
  localparam int RECIP_IN_W  = 21;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_MULT  = 2684355;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_KP_GAIN        = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KI_GAIN        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_LIMIT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PWM_PERIOD     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REF_HIGH       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_REF_LOW        = 3'd5;

  // stream widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,
    S_MAC_I,
    S_CLAMP,
    S_MUL_D,
    S_RECIP,
    S_DONE
  } state_t;

  // shared unit operations
  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_MUL_P,
    ALU_MAC_I,
    ALU_CLAMP,
    ALU_MUL_D,
    ALU_MUL_R
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
  } alu_ctrl_t;

  // capture result of one transaction
  typedef struct packed {
    logic              active;
    logic [SLOT_W-1:0] slot;
    logic [ADC_W-1:0]  ref_val;
    logic [ADC_W-1:0]  adc;
    logic              valid;
  } cap_t;

endpackage

[src/pi_pwm_loop_square_ref.sv]
// top level of the pi pwm loop with square-wave reference and decimated capture
// holds configuration and the output register; uses pwl_pkg, pwl_seq, pwl_alu,
// pwl_capture
//
// Each input transaction carries one converter sample and an arm flag and gives
// exactly one result transaction: the pwm compare count plus the capture fields.
// A transaction is taken in the cycle that in_tready is high; the result is
// loaded into the output register as the sequencer returns to idle and
// in_tready rises in that same cycle; no new sample is taken while one is in
// work. One shared 23x23 multiplier is used four times in turn (proportional
// term, integral term, period scaling, and a reciprocal multiply that divides by
// the q8.8 full scale), with a clamp step between the integral term and the
// period scaling for the offset and saturation. A finished result sits in the
// output register until taken; the next sample is accepted meanwhile, and its
// own result waits in the sequencer, in_tready low, until that register frees.
// Configuration writes take effect at once and are meant for times when no
// transaction is in flight.
module pi_pwm_loop_square_ref (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: adc_sample [9:0], arm_capture [10], zero [15:11]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pwl_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: duty_count [15:0], capture_valid [16], captured_adc [26:17],
  // captured_ref [36:27], capture_slot [44:37], capture_active [45], zero [47:46]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pwl_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [pwl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pwl_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  logic signed [pwl_pkg::GAIN_W-1:0] kp_gain_r, ki_gain_r;
  logic [pwl_pkg::LIM_W-1:0]         integral_limit_r;
  logic [pwl_pkg::PER_W-1:0]         pwm_period_r;
  logic [pwl_pkg::ADC_W-1:0]         ref_high_r, ref_low_r;

  logic                              in_fire, load_out, out_free;
  logic                              out_tvalid_r;
  logic [pwl_pkg::OUT_DATA_W-1:0]    out_tdata_r;
  pwl_pkg::alu_ctrl_t                ctrl;
  pwl_pkg::cap_t                     cap;
  logic signed [pwl_pkg::ERR_W-1:0]  err;
  logic [pwl_pkg::DUTY_W-1:0]        duty;
  logic [pwl_pkg::ADC_W-1:0]         adc_sample;
  logic                              arm_capture;

  assign adc_sample  = in_tdata[pwl_pkg::ADC_W-1:0];
  assign arm_capture = in_tdata[pwl_pkg::ADC_W];
  assign in_fire     = in_tvalid & in_tready;
  assign out_free    = ~out_tvalid_r | out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_gain_r        <= '0;
      ki_gain_r        <= '0;
      integral_limit_r <= pwl_pkg::LIM_W'(400);
      pwm_period_r     <= pwl_pkg::PER_W'(186);
      ref_high_r       <= pwl_pkg::ADC_W'(800);
      ref_low_r        <= pwl_pkg::ADC_W'(200);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pwl_pkg::REG_KP_GAIN:        kp_gain_r        <= cfg_wr_data;
        pwl_pkg::REG_KI_GAIN:        ki_gain_r        <= cfg_wr_data;
        pwl_pkg::REG_INTEGRAL_LIMIT: integral_limit_r <= cfg_wr_data[pwl_pkg::LIM_W-1:0];
        pwl_pkg::REG_PWM_PERIOD:     pwm_period_r     <= cfg_wr_data;
        pwl_pkg::REG_REF_HIGH:       ref_high_r       <= cfg_wr_data[pwl_pkg::ADC_W-1:0];
        pwl_pkg::REG_REF_LOW:        ref_low_r        <= cfg_wr_data[pwl_pkg::ADC_W-1:0];
        default: ;
      endcase
    end
  end

  pwl_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_ready (in_tready),
    .load_out (load_out),
    .ctrl     (ctrl)
  );

  pwl_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .arm        (arm_capture),
    .adc_sample (adc_sample),
    .ref_high   (ref_high_r),
    .ref_low    (ref_low_r),
    .err        (err),
    .cap        (cap)
  );

  pwl_alu u_alu (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .arm            (arm_capture),
    .err_in         (err),
    .kp_gain        (kp_gain_r),
    .ki_gain        (ki_gain_r),
    .integral_limit (integral_limit_r),
    .pwm_period     (pwm_period_r),
    .duty           (duty)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {2'b00, cap.active, cap.slot, cap.ref_val, cap.adc, cap.valid, duty};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[16]) |->
      out_tdata_r[44:37] < pwl_pkg::SLOT_W'(pwl_pkg::CAPTURE_POINTS))
    else $error("capture slot beyond capture length");

  a_empty_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tdata_r[16]) |-> out_tdata_r[44:17] == '0)
    else $error("capture fields set without a captured pair");

endmodule

[src/pwl_seq.sv]
// sequencer stepping the shared multiply unit through one control step
// depends on pwl_pkg
module pwl_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 out_free,
  output logic                 in_ready,
  output logic                 load_out,
  output pwl_pkg::alu_ctrl_t   ctrl
);

  pwl_pkg::state_t               state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pwl_pkg::S_IDLE: begin
        if (in_fire) state_nxt = pwl_pkg::S_MUL_P;
      end
      pwl_pkg::S_MUL_P: state_nxt = pwl_pkg::S_MAC_I;
      pwl_pkg::S_MAC_I: state_nxt = pwl_pkg::S_CLAMP;
      pwl_pkg::S_CLAMP: state_nxt = pwl_pkg::S_MUL_D;
      pwl_pkg::S_MUL_D: state_nxt = pwl_pkg::S_RECIP;
      pwl_pkg::S_RECIP: state_nxt = pwl_pkg::S_DONE;
      pwl_pkg::S_DONE: begin
        if (out_free) state_nxt = pwl_pkg::S_IDLE;
      end
      default: state_nxt = pwl_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    load_out     = 1'b0;
    ctrl.op      = pwl_pkg::ALU_NOP;
    unique case (state_r)
      pwl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) ctrl.op = pwl_pkg::ALU_LOAD;
      end
      pwl_pkg::S_MUL_P: ctrl.op = pwl_pkg::ALU_MUL_P;
      pwl_pkg::S_MAC_I: ctrl.op = pwl_pkg::ALU_MAC_I;
      pwl_pkg::S_CLAMP: ctrl.op = pwl_pkg::ALU_CLAMP;
      pwl_pkg::S_MUL_D: ctrl.op = pwl_pkg::ALU_MUL_D;
      pwl_pkg::S_RECIP: ctrl.op = pwl_pkg::ALU_MUL_R;
      pwl_pkg::S_DONE:  load_out = out_free;
      default: ;
    endcase
  end

endmodule

[src/pwl_alu.sv]
// shared 23x23 multiplier and accumulator; the divide by the q8.8 full scale is
// a reciprocal multiply; holds the error integral; depends on pwl_pkg
module pwl_alu (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pwl_pkg::alu_ctrl_t                   ctrl,
  input  logic                                 arm,
  input  logic signed [pwl_pkg::ERR_W-1:0]     err_in,
  input  logic signed [pwl_pkg::GAIN_W-1:0]    kp_gain,
  input  logic signed [pwl_pkg::GAIN_W-1:0]    ki_gain,
  input  logic [pwl_pkg::LIM_W-1:0]            integral_limit,
  input  logic [pwl_pkg::PER_W-1:0]            pwm_period,
  output logic [pwl_pkg::DUTY_W-1:0]           duty
);

  localparam int SUM_W = pwl_pkg::INTEG_W + 1;

  logic signed [pwl_pkg::ERR_W-1:0]   err_r;
  logic signed [pwl_pkg::INTEG_W-1:0] integ_r;
  logic signed [pwl_pkg::ACC_W-1:0]   acc_r;

  logic signed [pwl_pkg::OPND_W-1:0]  opa, opb;
  logic signed [pwl_pkg::ACC_W-1:0]   prod;
  logic signed [SUM_W-1:0]            isum, ilim;
  logic signed [pwl_pkg::INTEG_W-1:0] integ_clamped;
  logic signed [pwl_pkg::ACC_W-1:0]   offs, u_clamped;

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.op)
      pwl_pkg::ALU_MUL_P: begin
        opa = pwl_pkg::OPND_W'(kp_gain);
        opb = pwl_pkg::OPND_W'(err_r);
      end
      pwl_pkg::ALU_MAC_I: begin
        opa = pwl_pkg::OPND_W'(ki_gain);
        opb = pwl_pkg::OPND_W'(integ_r);
      end
      pwl_pkg::ALU_MUL_D: begin
        opa = $signed({{(pwl_pkg::OPND_W - pwl_pkg::U_W){1'b0}},
                       acc_r[pwl_pkg::U_W-1:0]});
        opb = $signed({{(pwl_pkg::OPND_W - pwl_pkg::PER_W){1'b0}}, pwm_period});
      end
      pwl_pkg::ALU_MUL_R: begin
        opa = $signed({{(pwl_pkg::OPND_W - pwl_pkg::RECIP_IN_W){1'b0}},
                       acc_r[pwl_pkg::RECIP_PRE+pwl_pkg::RECIP_IN_W-1:pwl_pkg::RECIP_PRE]});
        opb = pwl_pkg::OPND_W'(pwl_pkg::RECIP_MULT);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = pwl_pkg::ACC_W'(opa) * pwl_pkg::ACC_W'(opb);

  // integral plus error, clamped to the limit
  always_comb begin
    isum = SUM_W'(integ_r) + SUM_W'(err_r);
    ilim = $signed({2'b00, integral_limit});
    if (isum > ilim) integ_clamped = pwl_pkg::INTEG_W'(ilim);
    else if (isum < -ilim) integ_clamped = pwl_pkg::INTEG_W'(-ilim);
    else integ_clamped = pwl_pkg::INTEG_W'(isum);
  end

  // drive plus offset, clamped to full scale
  always_comb begin
    offs = acc_r + pwl_pkg::ACC_W'(pwl_pkg::OFFSET_Q8);
    if (offs < 0) u_clamped = '0;
    else if (offs > pwl_pkg::ACC_W'(pwl_pkg::FULL_SCALE_Q8))
      u_clamped = pwl_pkg::ACC_W'(pwl_pkg::FULL_SCALE_Q8);
    else u_clamped = offs;
  end

  // integral state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (ctrl.op == pwl_pkg::ALU_LOAD && arm) begin
      integ_r <= '0;
    end else if (ctrl.op == pwl_pkg::ALU_MAC_I) begin
      integ_r <= integ_clamped;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      pwl_pkg::ALU_LOAD:  err_r <= err_in;
      pwl_pkg::ALU_MUL_P: acc_r <= prod;
      pwl_pkg::ALU_MAC_I: acc_r <= acc_r + prod;
      pwl_pkg::ALU_CLAMP: acc_r <= u_clamped;
      pwl_pkg::ALU_MUL_D: acc_r <= prod;
      pwl_pkg::ALU_MUL_R: acc_r <= prod;
      default: ;
    endcase
  end

  // quotient sits above the reciprocal shift
  assign duty = acc_r[pwl_pkg::RECIP_SHIFT+pwl_pkg::DUTY_W-1:pwl_pkg::RECIP_SHIFT];

endmodule

[src/pwl_capture.sv]
// square wave position, reference select, error and decimated capture state
// depends on pwl_pkg
module pwl_capture (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_fire,
  input  logic                               arm,
  input  logic [pwl_pkg::ADC_W-1:0]          adc_sample,
  input  logic [pwl_pkg::ADC_W-1:0]          ref_high,
  input  logic [pwl_pkg::ADC_W-1:0]          ref_low,
  output logic signed [pwl_pkg::ERR_W-1:0]   err,
  output pwl_pkg::cap_t                      cap
);

  logic [pwl_pkg::WAVE_W-1:0] pos_r;
  logic [pwl_pkg::DEC_W-1:0]  dec_r;
  logic [pwl_pkg::SLOT_W-1:0] pts_r;
  logic                       capturing_r;
  pwl_pkg::cap_t              cap_r;

  logic [pwl_pkg::ADC_W-1:0]  refv;
  logic                       run;
  logic [pwl_pkg::DEC_W-1:0]  dec_base, dec_inc, dec_nxt;
  logic [pwl_pkg::SLOT_W-1:0] pts_base, pts_nxt;
  logic                       hit, capturing_nxt;

  // reference level and error for this transaction
  assign refv = (pos_r < pwl_pkg::WAVE_W'(pwl_pkg::WAVE_PERIOD / 2)) ? ref_high : ref_low;
  assign err  = $signed({1'b0, refv}) - $signed({1'b0, adc_sample});

  // decimation and point count, with arming restart
  always_comb begin
    run           = arm | capturing_r;
    dec_base      = arm ? '0 : dec_r;
    pts_base      = arm ? '0 : pts_r;
    dec_inc       = dec_base + 1'b1;
    hit           = run && (dec_inc == pwl_pkg::DEC_W'(pwl_pkg::DECIMATE_BY));
    dec_nxt       = run ? (hit ? '0 : dec_inc) : dec_base;
    pts_nxt       = hit ? pts_base + 1'b1 : pts_base;
    capturing_nxt = run && (pts_nxt != pwl_pkg::SLOT_W'(pwl_pkg::CAPTURE_POINTS));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      dec_r       <= '0;
      pts_r       <= '0;
      capturing_r <= 1'b0;
    end else if (in_fire) begin
      pos_r       <= (pos_r == pwl_pkg::WAVE_W'(pwl_pkg::WAVE_PERIOD - 1)) ? '0 : pos_r + 1'b1;
      dec_r       <= dec_nxt;
      pts_r       <= pts_nxt;
      capturing_r <= capturing_nxt;
    end
  end

  // captured pair, zero when not taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cap_r.valid   <= hit;
      cap_r.adc     <= hit ? adc_sample : '0;
      cap_r.ref_val <= hit ? refv : '0;
      cap_r.slot    <= hit ? pts_base : '0;
      cap_r.active  <= capturing_nxt;
    end
  end

  assign cap = cap_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < pwl_pkg::WAVE_W'(pwl_pkg::WAVE_PERIOD - 1) ||
    pos_r == pwl_pkg::WAVE_W'(pwl_pkg::WAVE_PERIOD - 1))
    else $error("wave position out of range");

  a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
    dec_r < pwl_pkg::DEC_W'(pwl_pkg::DECIMATE_BY))
    else $error("decimation count reached its terminal value");

endmodule
